FILE: src/ngll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GLL latitude extractor package
// Shared types, character codes and digit helpers for the sentence parser.
// ----------------------------------------------------------------------------
package ngll_pkg;

	// Character codes used by the header match and the capture logic.
	localparam logic [7:0] CHR_CR     = 8'h0D;
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_G      = 8'h47;
	localparam logic [7:0] CHR_P      = 8'h50;
	localparam logic [7:0] CHR_L      = 8'h4C;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;
	localparam logic [7:0] CHR_POINT  = 8'h2E;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_NINE   = 8'h39;

	// Number of fraction digits kept after the decimal point.
	localparam logic [2:0] FRACTION_LEN = 3'd6;

	// Reset value of the capture limit register.
	localparam logic [7:0] CAPTURE_LIMIT_RESET = 8'd55;

	// Header match progress, followed by the capture phase.
	typedef enum logic [2:0] {
		ST_DOLLAR,
		ST_G1,
		ST_P,
		ST_G2,
		ST_L1,
		ST_L2,
		ST_CAPTURE
	} hdr_state_t;

	// One finished sentence result.
	typedef struct packed {
		logic        valid_lock;
		logic        point_found;
		logic [9:0]  lat_degrees;
		logic [6:0]  lat_minutes;
		logic [19:0] lat_fraction;
	} result_t;

	// True for the ASCII characters '0' to '9'.
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHR_ZERO) && (c <= CHR_NINE);
	endfunction

	// Digit value of a character; any non-digit counts as zero.
	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] diff;
		diff = c - CHR_ZERO;
		return is_digit(c) ? diff[3:0] : 4'd0;
	endfunction

	// Place weight of each fraction digit, most significant first.
	function automatic logic [16:0] frac_weight(input logic [2:0] idx);
		logic [16:0] w;
		case (idx)
			3'd0:    w = 17'd100000;
			3'd1:    w = 17'd10000;
			3'd2:    w = 17'd1000;
			3'd3:    w = 17'd100;
			3'd4:    w = 17'd10;
			3'd5:    w = 17'd1;
			default: w = 17'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: src/ngll_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GLL input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module ngll_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// The register is free when empty or when its byte moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Byte captured on every input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: src/ngll_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GLL sentence parser
// Matches the header, captures sentence characters and builds the latitude.
// ----------------------------------------------------------------------------
module ngll_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic [7:0]      byte_s1,
	input  logic [7:0]      capture_limit,
	input  logic            out_free,
	output logic            advance,
	output logic            res_load,
	output ngll_pkg::result_t res
);
	import ngll_pkg::*;

	hdr_state_t  state_q;
	hdr_state_t  state_next;
	logic [7:0]  count_q;
	logic [1:0]  comma_run_q;
	logic        lock_lost_q;
	logic        point_seen_q;
	logic [7:0]  hist_q [5];
	logic [9:0]  degree_q;
	logic [6:0]  minute_q;
	logic [19:0] fraction_q;
	logic [2:0]  frac_digits_q;

	logic        emit;
	logic        capture;
	logic        point_now;
	logic        locked;
	logic        good;
	logic [9:0]  degree_calc;
	logic [6:0]  minute_calc;
	logic [19:0] fraction_add;

	// Next header / capture state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_DOLLAR:  state_next = (byte_s1 == CHR_DOLLAR) ? ST_G1 : ST_DOLLAR;
			ST_G1:      state_next = (byte_s1 == CHR_G) ? ST_P : ST_DOLLAR;
			ST_P:       state_next = (byte_s1 == CHR_P) ? ST_G2 : ST_DOLLAR;
			ST_G2:      state_next = (byte_s1 == CHR_G) ? ST_L1 : ST_DOLLAR;
			ST_L1:      state_next = (byte_s1 == CHR_L) ? ST_L2 : ST_DOLLAR;
			ST_L2:      state_next = (byte_s1 == CHR_L) ? ST_CAPTURE : ST_DOLLAR;
			ST_CAPTURE: begin
				if ((byte_s1 == CHR_CR) || (count_q >= capture_limit)) begin
					state_next = ST_DOLLAR;
				end
			end
			default:    state_next = ST_DOLLAR;
		endcase
	end

	// Decide whether the byte is captured or ends the sentence.
	always_comb begin
		emit    = 1'b0;
		capture = 1'b0;
		unique case (state_q)
			ST_CAPTURE: begin
				emit    = (byte_s1 == CHR_CR) || (count_q >= capture_limit);
				capture = !emit;
			end
			default: begin
				emit    = 1'b0;
				capture = 1'b0;
			end
		endcase
	end

	// A byte moves on unless it ends a sentence while the result register is full.
	assign advance  = valid_s1 && (!emit || out_free);
	assign res_load = advance && emit;

	// Latitude fields read from the character history when the point arrives.
	assign point_now = !point_seen_q && (byte_s1 == CHR_POINT) && (count_q != 8'd0);
	assign minute_calc = 7'(digit_val(hist_q[1])) * 7'd10 + 7'(digit_val(hist_q[0]));
	always_comb begin
		if (is_digit(hist_q[4])) begin
			degree_calc = 10'(digit_val(hist_q[4])) * 10'd100
			            + 10'(digit_val(hist_q[3])) * 10'd10
			            + 10'(digit_val(hist_q[2]));
		end else begin
			degree_calc = 10'(digit_val(hist_q[3])) * 10'd10
			            + 10'(digit_val(hist_q[2]));
		end
	end
	assign fraction_add = 20'(digit_val(byte_s1)) * 20'(frac_weight(frac_digits_q));

	// Latitude fields and point_found are zero without lock or without a decimal point.
	assign locked = !lock_lost_q;
	assign good   = locked && point_seen_q;
	always_comb begin
		res.valid_lock   = locked;
		res.point_found  = good;
		res.lat_degrees  = good ? degree_q : 10'd0;
		res.lat_minutes  = good ? minute_q : 7'd0;
		res.lat_fraction = good ? fraction_q : 20'd0;
	end

	// Sentence state update, one byte per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_DOLLAR;
			count_q       <= 8'd0;
			comma_run_q   <= 2'd0;
			lock_lost_q   <= 1'b0;
			point_seen_q  <= 1'b0;
			degree_q      <= 10'd0;
			minute_q      <= 7'd0;
			fraction_q    <= 20'd0;
			frac_digits_q <= 3'd0;
			for (int i = 0; i < 5; i++) begin
				hist_q[i] <= 8'd0;
			end
		end else if (advance) begin
			state_q <= state_next;
			if (emit) begin
				count_q       <= 8'd0;
				comma_run_q   <= 2'd0;
				lock_lost_q   <= 1'b0;
				point_seen_q  <= 1'b0;
				degree_q      <= 10'd0;
				minute_q      <= 7'd0;
				fraction_q    <= 20'd0;
				frac_digits_q <= 3'd0;
				for (int i = 0; i < 5; i++) begin
					hist_q[i] <= 8'd0;
				end
			end else if (capture) begin
				// Track runs of consecutive commas.
				if (byte_s1 == CHR_COMMA) begin
					if (comma_run_q >= 2'd2) begin
						lock_lost_q <= 1'b1;
					end else begin
						comma_run_q <= comma_run_q + 2'd1;
					end
				end else begin
					comma_run_q <= 2'd0;
				end
				// Fraction digits after the point, or latitude at the point.
				if (point_seen_q) begin
					if (frac_digits_q < FRACTION_LEN) begin
						fraction_q    <= fraction_q + fraction_add;
						frac_digits_q <= frac_digits_q + 3'd1;
					end
				end else if (point_now) begin
					point_seen_q <= 1'b1;
					minute_q     <= minute_calc;
					degree_q     <= degree_calc;
				end
				hist_q[4] <= hist_q[3];
				hist_q[3] <= hist_q[2];
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= byte_s1;
				count_q   <= count_q + 8'd1;
			end
		end
	end

`ifndef SYNTHESIS
	// The fraction never takes more than six digits.
	a_frac_digits: assert property (@(posedge clk) disable iff (!arst_n)
		frac_digits_q <= FRACTION_LEN)
		else $error("fraction digit count out of range");

	// Before the point no fraction has been gathered.
	a_no_point_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		!point_seen_q |-> (frac_digits_q == 3'd0 && fraction_q == 20'd0))
		else $error("fraction gathered without a decimal point");

	// Outside the capture phase all sentence state is clear.
	a_header_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CAPTURE |-> (count_q == 8'd0 && !lock_lost_q && !point_seen_q))
		else $error("sentence state left over during header match");

	// A finished sentence restarts the header match with a cleared count.
	a_emit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == ST_DOLLAR && count_q == 8'd0))
		else $error("parser did not restart after a sentence");
`endif

endmodule

FILE: src/ngll_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GLL result register
// Holds one finished sentence result until the output transfer.
// ----------------------------------------------------------------------------
module ngll_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  ngll_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              valid_lock,
	output logic              point_found,
	output logic [9:0]        lat_degrees,
	output logic [6:0]        lat_minutes,
	output logic [19:0]       lat_fraction
);
	import ngll_pkg::*;

	logic    out_valid_q;
	result_t res_q;

	// The register can take a result when empty or when it is being drained.
	assign out_free = !out_valid_q || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign valid_lock   = res_q.valid_lock;
	assign point_found  = res_q.point_found;
	assign lat_degrees  = res_q.lat_degrees;
	assign lat_minutes  = res_q.lat_minutes;
	assign lat_fraction = res_q.lat_fraction;

endmodule

FILE: src/nmea_gll_latitude_extractor_top.sv
// Path: the byte that ends a sentence passes from the input register through the
// parser into the result register, which then presents the sentence result.
// Throughput: one byte per cycle; a byte that ends a sentence waits only while
// the result register still holds an untaken result.
// Reset: arst_n clears all control and sentence state; capture_limit returns to 55.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GLL latitude extractor
// Parses "$GPGLL" sentences from a byte stream and reports the latitude.
// ----------------------------------------------------------------------------
module nmea_gll_latitude_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_lock,
	output logic        point_found,
	output logic [9:0]  lat_degrees,
	output logic [6:0]  lat_minutes,
	output logic [19:0] lat_fraction
);
	import ngll_pkg::*;

	logic [7:0] capture_limit_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_load;
	logic       out_free;
	result_t    res;

	// Capture limit register; a write transfer is always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_limit_q <= CAPTURE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capture_limit_q <= cfg_data;
		end
	end

	// Input register.
	ngll_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Header match and sentence capture.
	ngll_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1),
		.capture_limit (capture_limit_q),
		.out_free      (out_free),
		.advance       (advance),
		.res_load      (res_load),
		.res           (res)
	);

	// Result register.
	ngll_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res          (res),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.valid_lock   (valid_lock),
		.point_found  (point_found),
		.lat_degrees  (lat_degrees),
		.lat_minutes  (lat_minutes),
		.lat_fraction (lat_fraction)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the NMEA GLL latitude extractor
// Streams "$GPGLL" sentences, broken headers and noise into the parser and
// checks every latitude result against an in-bench model of the parser.
// Several capture limits and several idle and stall patterns are exercised.
// ----------------------------------------------------------------------------
module testbench;
	import ngll_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valid_lock;
	logic        point_found;
	logic [9:0]  lat_degrees;
	logic [6:0]  lat_minutes;
	logic [19:0] lat_fraction;

	// Stimulus and expectation stores.
	logic [7:0] byte_q[$];
	result_t    latitude_expect_q[$];
	result_t    seen_result;
	result_t    wanted_result;

	// Pacing knobs, written by the sequence and read by the drivers.
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit holdoff_armed = 1'b0;
	bit holdoff_done = 1'b0;
	int holdoff_count = 0;

	int fault_count = 0;
	int results_checked = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;
	int random_limit;

	// Parser model state.
	hdr_state_t hunt_state;
	logic [7:0] cap_limit;
	logic [7:0] chars_taken;
	int         comma_streak;
	bit         lock_broken;
	bit         point_met;
	logic [7:0] recent[5];
	int         deg_acc;
	int         min_acc;
	int         frac_acc;
	int         frac_weight_now;

	string tail_fields[6] = '{"N", "S", "E", "W", "A", "V"};

	nmea_gll_latitude_extractor_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.valid_lock   (valid_lock),
		.point_found  (point_found),
		.lat_degrees  (lat_degrees),
		.lat_minutes  (lat_minutes),
		.lat_fraction (lat_fraction)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ASCII digit test and value; anything else reads as zero.
	function automatic bit numeral(input logic [7:0] c);
		return (c >= CHR_ZERO) && (c <= CHR_NINE);
	endfunction

	function automatic int numeral_value(input logic [7:0] c);
		return numeral(c) ? int'(c - CHR_ZERO) : 0;
	endfunction

	// Clears everything that belongs to one sentence.
	task automatic restart_sentence();
		chars_taken = 8'd0;
		comma_streak = 0;
		lock_broken = 1'b0;
		point_met = 1'b0;
		foreach (recent[i]) recent[i] = 8'd0;
		deg_acc = 0;
		min_acc = 0;
		frac_acc = 0;
		frac_weight_now = 100000;
	endtask

	// Advances the parser model by one byte and queues any finished sentence.
	task automatic parse_gll_byte(input logic [7:0] b);
		logic [7:0] wanted_char;
		bit         good;
		result_t    r;
		if (hunt_state != ST_CAPTURE) begin
			case (hunt_state) inside
				ST_DOLLAR:   wanted_char = CHR_DOLLAR;
				ST_G1, ST_G2: wanted_char = CHR_G;
				ST_P:        wanted_char = CHR_P;
				default:     wanted_char = CHR_L;
			endcase
			hunt_state = (b == wanted_char) ? hdr_state_t'(hunt_state + 1) : ST_DOLLAR;
		end else if (b != CHR_CR && chars_taken < cap_limit) begin
			// Three commas in a row break the lock for the rest of the sentence.
			if (b == CHR_COMMA) begin
				if (comma_streak >= 2) lock_broken = 1'b1;
				else comma_streak++;
			end else begin
				comma_streak = 0;
			end
			// Fraction digits after the point, or the point itself.
			if (point_met) begin
				if (frac_weight_now != 0) begin
					frac_acc += numeral_value(b) * frac_weight_now;
					frac_weight_now /= 10;
				end
			end else if (b == CHR_POINT && chars_taken != 8'd0) begin
				point_met = 1'b1;
				min_acc = numeral_value(recent[1]) * 10 + numeral_value(recent[0]);
				if (numeral(recent[4])) begin
					deg_acc = numeral_value(recent[4]) * 100 + numeral_value(recent[3]) * 10
						+ numeral_value(recent[2]);
				end else begin
					deg_acc = numeral_value(recent[3]) * 10 + numeral_value(recent[2]);
				end
			end
			for (int i = 4; i > 0; i--) recent[i] = recent[i - 1];
			recent[0] = b;
			chars_taken = chars_taken + 8'd1;
		end else begin
			// The ending byte is consumed and produces the result.
			good = !lock_broken && point_met;
			r.valid_lock = !lock_broken;
			r.point_found = good;
			r.lat_degrees = good ? deg_acc[9:0] : 10'd0;
			r.lat_minutes = good ? min_acc[6:0] : 7'd0;
			r.lat_fraction = good ? frac_acc[19:0] : 20'd0;
			latitude_expect_q.push_back(r);
			restart_sentence();
			hunt_state = ST_DOLLAR;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		byte_q.push_back(b);
	endtask

	task automatic queue_text(input string t);
		for (int i = 0; i < t.len(); i++) byte_q.push_back(t[i]);
	endtask

	task automatic queue_line(input string t);
		queue_text(t);
		push_byte(CHR_CR);
	endtask

	// A digit, now and then replaced by some other printable character.
	task automatic push_digit();
		if ($urandom_range(14) == 0) push_byte(8'($urandom_range(8'h21, 8'h7E)));
		else push_byte(8'(CHR_ZERO + $urandom_range(9)));
	endtask

	// One random chunk: mostly well-formed sentences, some noise and cut headers.
	task automatic queue_random_sentence();
		int    pick;
		string hdr_text;
		hdr_text = "$GPGLL";
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
		end else if (pick < 18) begin
			queue_text(hdr_text.substr(0, $urandom_range(0, 4)));
			push_byte(8'($urandom_range(255)));
		end else begin
			queue_text(hdr_text);
			if ($urandom_range(9) != 0) push_byte(CHR_COMMA);
			repeat ($urandom_range(2, 3)) push_digit();
			repeat (2) push_digit();
			if ($urandom_range(9) != 0) push_byte(CHR_POINT);
			repeat ($urandom_range(0, 8)) push_digit();
			repeat ($urandom_range(0, 6)) begin
				push_byte(CHR_COMMA);
				if ($urandom_range(11) == 0) queue_text(",,");
				if ($urandom_range(1) == 0) queue_text(tail_fields[$urandom_range(5)]);
				else repeat ($urandom_range(0, 6)) push_digit();
			end
			// Rarely a very long body, to run into the largest capture limit.
			if ($urandom_range(39) == 0) begin
				repeat ($urandom_range(60, 260)) push_byte(8'($urandom_range(8'h20, 8'h7E)));
			end
			if ($urandom_range(99) < 85) push_byte(CHR_CR);
		end
	endtask

	task automatic queue_random_bytes(input int count);
		int start;
		start = byte_q.size();
		while (byte_q.size() - start < count) queue_random_sentence();
		// A closing carriage return leaves the parser hunting for a header.
		push_byte(CHR_CR);
	endtask

	// Waits until every byte is taken and every result has come back.
	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || latitude_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capture_limit(input logic [7:0] limit);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_limit = limit;
	endtask

	// Byte sender: offers queued bytes and feeds each transfer to the model.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'd0;
		end else begin
			if (in_valid && in_ready) begin
				parse_gll_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver ready, with one long hold-off when armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			holdoff_count <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_armed && !holdoff_done) begin
			out_ready <= 1'b0;
			holdoff_count <= holdoff_count + 1;
			if (holdoff_count == HOLDOFF_CYCLES - 1) holdoff_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: each transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result = {valid_lock, point_found, lat_degrees, lat_minutes, lat_fraction};
			if (latitude_expect_q.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("ERROR: result with nothing expected: %p", seen_result);
			end else begin
				wanted_result = latitude_expect_q.pop_front();
				results_checked++;
				if (seen_result.valid_lock !== wanted_result.valid_lock
						|| seen_result.point_found !== wanted_result.point_found
						|| seen_result.lat_degrees !== wanted_result.lat_degrees
						|| seen_result.lat_minutes !== wanted_result.lat_minutes
						|| seen_result.lat_fraction !== wanted_result.lat_fraction) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("ERROR: result %0d expected lock %b point %b deg %0d min %0d frac %0d",
							results_checked, wanted_result.valid_lock, wanted_result.point_found,
							wanted_result.lat_degrees, wanted_result.lat_minutes,
							wanted_result.lat_fraction);
						$display("       got      lock %b point %b deg %0d min %0d frac %0d",
							seen_result.valid_lock, seen_result.point_found,
							seen_result.lat_degrees, seen_result.lat_minutes,
							seen_result.lat_fraction);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Test sequence.
	initial begin
		hunt_state = ST_DOLLAR;
		cap_limit = CAPTURE_LIMIT_RESET;
		restart_sentence();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sentences at the reset capture limit, no idling.
		queue_line("$GPGLL,4916.45,N,12311.12,W,225444,A");
		queue_line("$GPGLL,12311.123456789");
		queue_line("$$GPGLL,1.5");
		queue_line("$GPGLL.12.3");
		queue_line("$GPGLL1.25");
		queue_line("$GPGLL,,,4916.45,N");
		queue_line("$GPGLL,,4x16.5y");
		queue_line("$GPGLL,4916,N");
		queue_line("$GPGLL");
		queue_line("$GPGLL999,99.999999");
		queue_text("$GPGLL");
		push_byte(8'hFF);
		push_byte(8'h00);
		queue_line("12.5");
		queue_text("$GPGLL,4916.4");
		repeat (60) push_byte(CHR_NINE);
		push_byte(CHR_CR);
		wait_idle();

		// Largest capture limit, sender idling.
		write_capture_limit(8'd255);
		send_idle_pct = 73;
		queue_random_bytes(450);
		wait_idle();

		// Smallest capture limit, results back to back, long output hold-off.
		write_capture_limit(8'd1);
		send_idle_pct = 0;
		holdoff_armed = 1'b1;
		queue_random_bytes(300);
		wait_idle();

		// Random capture limit, receiver stalling.
		random_limit = $urandom_range(2, 80);
		write_capture_limit(8'(random_limit));
		stall_pct = 73;
		queue_random_bytes(450);
		wait_idle();

		// Short capture limit, both sides idling.
		write_capture_limit(8'd12);
		send_idle_pct = 24;
		stall_pct = 24;
		queue_random_bytes(450);
		wait_idle();

		// Back to the reset limit with no idling.
		write_capture_limit(CAPTURE_LIMIT_RESET);
		send_idle_pct = 0;
		stall_pct = 0;
		queue_random_bytes(350);
		wait_idle();

		$display("Summary: %0d bytes sent, %0d sentence results checked, %0d errors.",
			bytes_sent, results_checked, fault_count);
		$display("Capture limits 55, 255, 1, %0d and 12; idle, stall and hold-off phases run.",
			random_limit);
		if (fault_count == 0 && latitude_expect_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
src/ngll_pkg.sv
src/ngll_in_stage.sv
src/ngll_parser.sv
src/ngll_out_stage.sv
src/nmea_gll_latitude_extractor_top.sv
dv/testbench.sv
